FILE: hw/rtl/brightest_pixel_locator_top_defines.svh
// Assertion macros for the brightest pixel locator.
`ifndef BRIGHTEST_PIXEL_LOCATOR_TOP_DEFINES_SVH
`define BRIGHTEST_PIXEL_LOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpl: same-cycle check failed");

// next-cycle implication, disabled during reset
`define BPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpl: next-cycle check failed");

`endif

FILE: hw/rtl/bpl_pkg.sv
// Shared constants and types for the brightest pixel locator.
package bpl_pkg;

   localparam int COORD_BITS    = 12;
   localparam int FRACTION_BITS = 16;

   localparam int DIM_W      = 12;
   localparam int STRIDE_W   = 8;
   localparam int LEVEL_W    = 8;
   localparam int BRIGHT_W   = 10;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int CMP_W  = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
   localparam int STEP_W = $clog2(FRACTION_BITS);

   localparam logic [DIM_W-1:0]    WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = DIM_W'(480);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(19);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_SAMPLE_STRIDE = 2'd2
   } reg_index_type;

endpackage

FILE: hw/rtl/bpl_if.sv
// Handshake channel interfaces for pixel items, result items and register writes.
interface bpl_req_if import bpl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

interface bpl_rsp_if import bpl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] x_fraction;
   logic [OUT_W-1:0] y_fraction;

   modport source (output valid, output x_fraction, output y_fraction, input ready);
   modport sink   (input valid, input x_fraction, input y_fraction, output ready);
endinterface

interface bpl_csr_if import bpl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/brightest_pixel_locator_top.sv
// Brightest pixel locator: sampled peak search with a shared serial divider.
// Ordinary pixel: one item per cycle while no frame end is pending.
// Frame-end pixel: ST_DIV_X, then ST_DIV_Y, then ST_LOAD into the result register,
// using one restoring compare-subtract unit once per quotient bit.
// Ready is low while the divider runs and while a finished result waits for the slot.
// Synchronous active-high reset: registers back to 640 x 480, stride 19, counters zero.
`include "brightest_pixel_locator_top_defines.svh"

module brightest_pixel_locator_top import bpl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   bpl_req_if.sink  req_if,
   bpl_rsp_if.source rsp_if,
   bpl_csr_if.sink  csr_if
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_LOAD} state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]      frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]      frame_height_ff, frame_height_in;
   logic [STRIDE_W-1:0]   sample_stride_ff, sample_stride_in;

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [STRIDE_W-1:0]   phase_ff, phase_in;
   logic [BRIGHT_W-1:0]   best_bright_ff, best_bright_in;
   logic [COORD_BITS-1:0] best_col_ff, best_col_in;
   logic [COORD_BITS-1:0] best_row_ff, best_row_in;

   logic [DIM_W-1:0]         rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [FRACTION_BITS-1:0] xq_ff, xq_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     sat_ff, sat_in;
   logic [COORD_BITS-1:0]    ypos_ff, ypos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_x_ff, rsp_x_in;
   logic [OUT_W-1:0] rsp_y_ff, rsp_y_in;

   logic [DIM_W-1:0]      w_eff, h_eff, divisor;
   logic [STRIDE_W-1:0]   s_eff;
   logic [BRIGHT_W-1:0]   bright;
   logic                  take;
   logic [COORD_BITS-1:0] best_col_nx, best_row_nx;
   logic [BRIGHT_W-1:0]   best_bright_nx;
   logic [STRIDE_W:0]     phase_inc;
   logic [CMP_W-1:0]      col_inc, row_inc;
   logic                  row_end, frame_end, req_fire, slot_free, last_step;
   logic [DIM_W:0]        trial, trial_sub;
   logic                  fits;
   logic [FRACTION_BITS-1:0] quo_shift;

   assign w_eff = (frame_width_ff == '0) ? DIM_W'(1) : frame_width_ff;
   assign h_eff = (frame_height_ff == '0) ? DIM_W'(1) : frame_height_ff;
   assign s_eff = (sample_stride_ff == '0) ? STRIDE_W'(1) : sample_stride_ff;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.x_fraction = rsp_x_ff;
   assign rsp_if.y_fraction = rsp_y_ff;
   assign slot_free         = !rsp_valid_ff || rsp_if.ready;

   // pixel datapath
   assign bright = BRIGHT_W'(req_if.red_level) + BRIGHT_W'(req_if.green_level)
                 + BRIGHT_W'(req_if.blue_level);
   assign take           = (phase_ff == '0) && (bright > best_bright_ff);
   assign best_bright_nx = take ? bright : best_bright_ff;
   assign best_col_nx    = take ? column_ff : best_col_ff;
   assign best_row_nx    = take ? row_ff : best_row_ff;
   assign phase_inc      = {1'b0, phase_ff} + (STRIDE_W+1)'(1);
   assign col_inc        = CMP_W'(column_ff) + CMP_W'(1);
   assign row_inc        = CMP_W'(row_ff) + CMP_W'(1);
   assign row_end        = col_inc >= CMP_W'(w_eff);
   assign frame_end      = row_end && (row_inc >= CMP_W'(h_eff));

   // shared restoring divider step
   assign divisor   = (state_ff == ST_DIV_Y) ? h_eff : w_eff;
   assign trial     = {rem_ff, 1'b0};
   assign fits      = trial >= {1'b0, divisor};
   assign trial_sub = fits ? (trial - {1'b0, divisor}) : trial;
   assign quo_shift = {quo_ff[FRACTION_BITS-2:0], fits};
   assign last_step = (step_ff == STEP_W'(FRACTION_BITS - 1));

   always_comb begin
      state_in         = state_ff;
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      sample_stride_in = sample_stride_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      phase_in         = phase_ff;
      best_bright_in   = best_bright_ff;
      best_col_in      = best_col_ff;
      best_row_in      = best_row_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      xq_in            = xq_ff;
      step_in          = step_ff;
      sat_in           = sat_ff;
      ypos_in          = ypos_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_x_in         = rsp_x_ff;
      rsp_y_in         = rsp_y_ff;

      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            REG_FRAME_WIDTH:   frame_width_in   = DIM_W'(csr_if.data);
            REG_FRAME_HEIGHT:  frame_height_in  = DIM_W'(csr_if.data);
            REG_SAMPLE_STRIDE: sample_stride_in = STRIDE_W'(csr_if.data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               phase_in = (phase_inc >= {1'b0, s_eff}) ? '0 : phase_inc[STRIDE_W-1:0];
               if (frame_end) begin
                  // hand the winner to the divider, clear for the next frame
                  rem_in         = DIM_W'(best_col_nx);
                  sat_in         = CMP_W'(best_col_nx) >= CMP_W'(w_eff);
                  ypos_in        = best_row_nx;
                  step_in        = '0;
                  state_in       = ST_DIV_X;
                  column_in      = '0;
                  row_in         = '0;
                  phase_in       = '0;
                  best_bright_in = '0;
                  best_col_in    = '0;
                  best_row_in    = '0;
               end else begin
                  best_bright_in = best_bright_nx;
                  best_col_in    = best_col_nx;
                  best_row_in    = best_row_nx;
                  if (row_end) begin
                     column_in = '0;
                     row_in    = COORD_BITS'(row_inc);
                  end else begin
                     column_in = COORD_BITS'(col_inc);
                  end
               end
            end
         end
         ST_DIV_X: begin
            rem_in  = trial_sub[DIM_W-1:0];
            quo_in  = quo_shift;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               xq_in    = sat_ff ? '1 : quo_shift;
               rem_in   = DIM_W'(ypos_ff);
               sat_in   = CMP_W'(ypos_ff) >= CMP_W'(h_eff);
               step_in  = '0;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            rem_in  = trial_sub[DIM_W-1:0];
            quo_in  = quo_shift;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               quo_in   = sat_ff ? '1 : quo_shift;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = OUT_W'(xq_ff);
               rsp_y_in     = OUT_W'(quo_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         frame_width_ff   <= WIDTH_RESET;
         frame_height_ff  <= HEIGHT_RESET;
         sample_stride_ff <= STRIDE_RESET;
         column_ff        <= '0;
         row_ff           <= '0;
         phase_ff         <= '0;
         best_bright_ff   <= '0;
         best_col_ff      <= '0;
         best_row_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         sample_stride_ff <= sample_stride_in;
         column_ff        <= column_in;
         row_ff           <= row_in;
         phase_ff         <= phase_in;
         best_bright_ff   <= best_bright_in;
         best_col_ff      <= best_col_in;
         best_row_ff      <= best_row_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      xq_ff    <= xq_in;
      step_ff  <= step_in;
      sat_ff   <= sat_in;
      ypos_ff  <= ypos_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   `BPL_ASSERT_NOW(a_best_zero_at_origin, clock, reset, best_bright_ff == '0,
                   best_col_ff == '0 && best_row_ff == '0)
   `BPL_ASSERT_NOW(a_result_from_load, clock, reset, $rose(rsp_valid_ff),
                   $past(state_ff) == ST_LOAD)
   `BPL_ASSERT_NEXT(a_x_then_y, clock, reset, state_ff == ST_DIV_X && last_step,
                    state_ff == ST_DIV_Y && step_ff == '0)

endmodule
